/* hdl/b64e_pkg.sv */
package b64e_pkg;

   localparam int unsigned CharWidth     = 8;
   localparam int unsigned CountWidth    = 16;
   localparam int unsigned MaxListChars  = 4;
   localparam logic [CharWidth-1:0]  PadChar       = 8'h3D;
   localparam logic [CountWidth-1:0] MaxCharsReset = 16'hFFFF;

   // Characters produced by one input byte, ready to be sent one per cycle while the receiver is ready.
   typedef struct packed {
      logic [MaxListChars-1:0][CharWidth-1:0] chars;
      logic [2:0]                             count;  // 1 to 4
      logic                                   last;
   } list_type;

   // Standard base64 alphabet.
   function automatic logic [CharWidth-1:0] b64_char(input logic [5:0] v);
      logic [CharWidth-1:0] r;
      if (v < 6'd26) begin
         r = 8'h41 + {2'b00, v};
      end else if (v < 6'd52) begin
         r = 8'h47 + {2'b00, v};
      end else if (v < 6'd62) begin
         r = {2'b00, v} - 8'd4;
      end else if (v == 6'd62) begin
         r = 8'h2B;
      end else begin
         r = 8'h2F;
      end
      return r;
   endfunction

endpackage

/* hdl/b64e_load.sv */
module b64e_load
   import b64e_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_tvalid,
   output logic           req_tready,
   input  logic [7:0]     req_tdata,   // data_byte
   input  logic           req_tlast,   // last_byte
   output logic           item_valid,
   output list_type       item,
   input  logic           item_take
);

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;
   logic [3:0] lo_bits_ff, lo_bits_in;
   logic [2:0] lo_cnt_ff, lo_cnt_in;
   logic       req_xfer;
   logic       commit;

   assign commit     = in_valid_ff && item_take;
   assign req_tready = !in_valid_ff || item_take;
   assign req_xfer   = req_tvalid && req_tready;
   assign item_valid = in_valid_ff;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_xfer) begin
         in_valid_in = 1'b1;
      end else if (commit) begin
         in_valid_in = 1'b0;
      end
   end

   // Split byte plus carried bits into characters; a last byte flushes
   // the remainder, zero filled, followed by padding.
   always_comb begin
      item.chars = {MaxListChars{PadChar}};
      item.last  = in_last_ff;
      item.count = 3'd1;
      lo_bits_in = 4'd0;
      lo_cnt_in  = 3'd0;
      case (lo_cnt_ff)
         3'd2: begin
            item.chars[0] = b64_char({lo_bits_ff[1:0], in_byte_ff[7:4]});
            if (in_last_ff) begin
               item.chars[1] = b64_char({in_byte_ff[3:0], 2'b00});
               item.count    = 3'd3;
            end else begin
               lo_bits_in = in_byte_ff[3:0];
               lo_cnt_in  = 3'd4;
            end
         end
         3'd4: begin
            item.chars[0] = b64_char({lo_bits_ff, in_byte_ff[7:6]});
            item.chars[1] = b64_char(in_byte_ff[5:0]);
            item.count    = 3'd2;
         end
         default: begin
            item.chars[0] = b64_char(in_byte_ff[7:2]);
            if (in_last_ff) begin
               item.chars[1] = b64_char({in_byte_ff[1:0], 4'b0000});
               item.count    = 3'd4;
            end else begin
               lo_bits_in = {2'b00, in_byte_ff[1:0]};
               lo_cnt_in  = 3'd2;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         lo_bits_ff  <= 4'd0;
         lo_cnt_ff   <= 3'd0;
      end else begin
         in_valid_ff <= in_valid_in;
         // leftover from a dropped byte is harmless: the last byte zeroes it
         if (commit) begin
            lo_bits_ff <= lo_bits_in;
            lo_cnt_ff  <= lo_cnt_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

`ifndef SYNTHESIS
   a_lo_cnt_legal: assert property (@(posedge clock) disable iff (reset)
      lo_cnt_ff == 3'd0 || lo_cnt_ff == 3'd2 || lo_cnt_ff == 3'd4)
      else $error("leftover count out of range");
   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      commit && in_last_ff |=> lo_cnt_ff == 3'd0)
      else $error("leftover not cleared at end of message");
   a_hold_full: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !item_take |=> in_valid_ff && $stable(in_byte_ff))
      else $error("held input byte lost");
`endif

endmodule

/* hdl/b64e_emit.sv */
module b64e_emit
   import b64e_pkg::*;
#(
   parameter logic [CountWidth-1:0] MAX_CHARS_RESET = MaxCharsReset
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CountWidth-1:0] csr_wdata,
   input  logic                  item_valid,
   input  list_type              item,
   output logic                  item_take,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [CharWidth-1:0]  rsp_tdata,
   output logic                  rsp_tlast,
   output logic                  rsp_tuser
);

   logic [CountWidth-1:0] max_chars_ff;
   logic                  list_valid_ff, list_valid_in;
   list_type              list_ff;
   logic [1:0]            idx_ff, idx_in;
   logic [CountWidth-1:0] emitted_ff, emitted_in;
   logic                  stopped_ff, stopped_in;
   logic                  out_valid_ff, out_valid_in;
   logic [CharWidth-1:0]  out_char_ff;
   logic                  out_last_ff, out_trunc_ff;

   logic [CountWidth-1:0] limit, emitted_inc;
   logic                  out_free, drop, emit, final_idx, final_nat, cut, done;

   assign limit       = (max_chars_ff == '0) ? CountWidth'(1) : max_chars_ff;
   assign emitted_inc = emitted_ff + CountWidth'(1);
   assign out_free    = !out_valid_ff || rsp_tready;
   assign drop        = list_valid_ff && stopped_ff;
   assign emit        = list_valid_ff && !stopped_ff && out_free;
   assign final_idx   = ({1'b0, idx_ff} + 3'd1) == list_ff.count;
   assign final_nat   = list_ff.last && final_idx;
   assign cut         = (emitted_inc >= limit) && !final_nat;
   assign done        = drop || (emit && (cut || final_idx));
   assign item_take   = !list_valid_ff || done;

   always_comb begin
      list_valid_in = list_valid_ff;
      idx_in        = idx_ff;
      emitted_in    = emitted_ff;
      stopped_in    = stopped_ff;
      out_valid_in  = out_valid_ff && !rsp_tready;
      if (emit) begin
         out_valid_in = 1'b1;
         idx_in       = idx_ff + 2'd1;
         emitted_in   = emitted_inc;
         if (final_nat || (cut && list_ff.last)) begin
            emitted_in = '0;
         end else if (cut) begin
            stopped_in = 1'b1;
         end
      end
      if (drop && list_ff.last) begin
         stopped_in = 1'b0;
         emitted_in = '0;
      end
      if (item_take) begin
         list_valid_in = item_valid;
         idx_in        = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_chars_ff  <= MAX_CHARS_RESET;
         list_valid_ff <= 1'b0;
         idx_ff        <= 2'd0;
         emitted_ff    <= '0;
         stopped_ff    <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (csr_we) begin
            max_chars_ff <= csr_wdata;
         end
         list_valid_ff <= list_valid_in;
         idx_ff        <= idx_in;
         emitted_ff    <= emitted_in;
         stopped_ff    <= stopped_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (item_take) begin
         list_ff <= item;
      end
      if (emit) begin
         out_char_ff  <= list_ff.chars[idx_ff];
         out_last_ff  <= final_nat || cut;
         out_trunc_ff <= cut;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_char_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = out_trunc_ff;

`ifndef SYNTHESIS
   a_trunc_is_last: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_trunc_ff |-> out_last_ff)
      else $error("truncated character not marked last");
   a_stopped_count: assert property (@(posedge clock) disable iff (reset)
      stopped_ff |-> emitted_ff != '0)
      else $error("stopped with empty character count");
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      list_valid_ff |-> {1'b0, idx_ff} < list_ff.count)
      else $error("character index past list end");
   a_cut_stops: assert property (@(posedge clock) disable iff (reset)
      emit && cut && !list_ff.last |=> stopped_ff)
      else $error("message not stopped after cut");
`endif

endmodule

/* hdl/base64_stream_encoder_core.sv */
// Streaming base64 encoder (standard alphabet, '=' padding). Each input
// transfer carries one byte, with tlast on the final byte of a message; each
// output transfer carries one ASCII character, with tlast on the message's
// final character and tuser set when that character was cut off by the
// character limit (csr_wdata, 0 acts as 1, reset 65535). A byte yields one or
// two characters, and the last byte up to four including padding; the output
// register sends one character per cycle while the receiver is ready, and a
// byte dropped after a cut yields no characters. The first character of a byte
// passes through the input byte register, the list register and the output
// register before it is valid on the output. Write the limit only while no
// message is in flight.
module base64_stream_encoder_core
   import b64e_pkg::*;
#(
   parameter logic [CountWidth-1:0] MAX_CHARS_RESET = MaxCharsReset
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CountWidth-1:0] csr_wdata,   // max_chars
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // [7:0] data_byte
   input  logic                  req_tlast,   // last_byte
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [CharWidth-1:0]  rsp_tdata,   // [7:0] out_char
   output logic                  rsp_tlast,   // out_last
   output logic                  rsp_tuser    // [0] truncated
);

   logic     item_valid;
   list_type item;
   logic     item_take;

   b64e_load u_load (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .item_valid (item_valid),
      .item       (item),
      .item_take  (item_take)
   );

   b64e_emit #(
      .MAX_CHARS_RESET (MAX_CHARS_RESET)
   ) u_emit (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .item_valid (item_valid),
      .item       (item),
      .item_take  (item_take),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

/* verif/b64_stream_checker.sv */
module b64_stream_checker
   import b64e_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CountWidth-1:0] csr_wdata,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [7:0]            req_tdata,
   input  logic                  req_tlast,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [CharWidth-1:0]  rsp_tdata,
   input  logic                  rsp_tlast,
   input  logic                  rsp_tuser,
   output int                    fail_count,
   output int                    pending_chars,
   output int                    chars_checked,
   output int                    cut_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [8*64-1:0] Alphabet =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

   typedef struct packed {
      logic [CharWidth-1:0] ch;
      logic                 last;
      logic                 cut;
   } char_exp_type;

   char_exp_type expected_chars[$];
   char_exp_type want;

   // encoder state, mirrors the block
   logic [CountWidth-1:0] limit_q;
   logic [3:0]            lo_bits;
   logic [2:0]            lo_count;
   logic [CountWidth-1:0] emitted;
   logic                  stopped;

   function automatic logic [CharWidth-1:0] b64_symbol(input logic [5:0] v);
      return Alphabet[8*(63-v) +: 8];
   endfunction

   function automatic void clear_message();
      lo_bits  = '0;
      lo_count = '0;
      emitted  = '0;
      stopped  = 1'b0;
   endfunction

   // Expected characters for one accepted byte.
   function automatic void encode_byte(input logic [7:0] b, input logic is_last);
      logic [11:0]          acc;
      logic [11:0]          sh;
      int unsigned          cnt;
      logic [CharWidth-1:0] chars [4];
      int                   n;
      int                   k;
      logic [CountWidth-1:0] lim;
      logic                 final_nat;
      logic                 cut;
      if (stopped) begin
         if (is_last) clear_message();
         return;
      end
      cnt = (lo_count == 3'd2 || lo_count == 3'd4) ? lo_count : 0;
      acc = {lo_bits, b};
      cnt = cnt + 8;
      n = 0;
      while (cnt >= 6) begin
         cnt = cnt - 6;
         sh = acc >> cnt;
         chars[n] = b64_symbol(sh[5:0]);
         n = n + 1;
      end
      acc = acc & ((12'd1 << cnt) - 12'd1);
      if (is_last && cnt > 0) begin
         sh = acc << (6 - cnt);
         chars[n] = b64_symbol(sh[5:0]);
         n = n + 1;
         while (cnt < 6) begin
            chars[n] = PadChar;
            n = n + 1;
            cnt = cnt + 2;
         end
         cnt = 0;
         acc = '0;
      end
      lim = (limit_q == '0) ? 16'd1 : limit_q;
      for (k = 0; k < n; k++) begin
         final_nat = is_last && (k == n - 1);
         emitted = emitted + 1'b1;
         cut = (emitted >= lim) && !final_nat;
         expected_chars.push_back('{ch: chars[k], last: final_nat || cut, cut: cut});
         if (cut) begin
            if (is_last) begin
               clear_message();
            end else begin
               lo_bits  = '0;
               lo_count = '0;
               stopped  = 1'b1;
            end
            return;
         end
      end
      if (is_last) begin
         clear_message();
      end else begin
         lo_bits  = acc[3:0];
         lo_count = cnt[2:0];
      end
   endfunction

   task automatic report_mismatch(input string msg);
      fail_count = fail_count + 1;
      if (fail_count <= 40) $display("[%0t] MISMATCH: %s", $time, msg);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         limit_q = MaxCharsReset;
         clear_message();
         expected_chars.delete();
         pending_chars = 0;
      end else begin
         if (csr_we) limit_q = csr_wdata;
         if (rsp_tvalid && rsp_tready) begin
            if (expected_chars.size() == 0) begin
               report_mismatch($sformatf("unexpected char 0x%02h last=%b cut=%b",
                                         rsp_tdata, rsp_tlast, rsp_tuser));
            end else begin
               want = expected_chars.pop_front();
               chars_checked = chars_checked + 1;
               if (want.cut) cut_count = cut_count + 1;
               if (rsp_tdata !== want.ch)
                  report_mismatch($sformatf("char 0x%02h, want 0x%02h (#%0d)",
                                            rsp_tdata, want.ch, chars_checked));
               if (rsp_tlast !== want.last)
                  report_mismatch($sformatf("last %b, want %b (#%0d)",
                                            rsp_tlast, want.last, chars_checked));
               if (rsp_tuser !== want.cut)
                  report_mismatch($sformatf("truncated %b, want %b (#%0d)",
                                            rsp_tuser, want.cut, chars_checked));
            end
         end
         if (req_tvalid && req_tready) encode_byte(req_tdata, req_tlast);
         pending_chars = expected_chars.size();
      end
   end

endmodule

/* verif/base64_stream_encoder_core_test.sv */
module base64_stream_encoder_core_test;
   import b64e_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DrainCycles = 10;
   localparam int HoldCycles  = 200;

   logic                  clock;
   logic                  reset      = 1'b1;
   logic                  csr_we     = 1'b0;
   logic [CountWidth-1:0] csr_wdata  = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [7:0]            req_tdata  = '0;
   logic                  req_tlast  = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [CharWidth-1:0]  rsp_tdata;
   logic                  rsp_tlast;
   logic                  rsp_tuser;

   int fail_count;
   int pending_chars;
   int chars_checked;
   int cut_count;

   int send_idle_pct = 0;
   int stall_pct     = 0;
   int hold_req      = 0;
   int hold_seen     = 0;
   int hold_left     = 0;
   int bytes_sent    = 0;
   int messages_sent = 0;
   int phase;
   int phase_bytes;
   int len;

   base64_stream_encoder_core dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   b64_stream_checker checker_i (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_wdata     (csr_wdata),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tlast     (req_tlast),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tlast     (rsp_tlast),
      .rsp_tuser     (rsp_tuser),
      .fail_count    (fail_count),
      .pending_chars (pending_chars),
      .chars_checked (chars_checked),
      .cut_count     (cut_count)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // receiver: random stalls, plus a long hold-off when requested
   always @(posedge clock) begin
      if (hold_req != hold_seen) begin
         hold_seen = hold_req;
         hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic is_last);
      int gap;
      gap = 0;
      while (gap < 40 && $urandom_range(99) < send_idle_pct) gap = gap + 1;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= is_last;
      do @(posedge clock); while (!req_tready);
      bytes_sent = bytes_sent + 1;
      if (is_last) messages_sent = messages_sent + 1;
   endtask

   task automatic send_message(input int n);
      int i;
      for (i = 0; i < n; i++) send_byte(8'($urandom_range(255)), i == n - 1);
   endtask

   // also covers bytes dropped after a cut, which return nothing
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_chars != 0);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic set_limit(input logic [CountWidth-1:0] v);
      wait_drained();
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   initial begin
      #2_000_000;
      $display("timeout: %0d characters still outstanding", pending_chars);
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // plain encoding at the reset limit, all padding lengths
      send_byte(8'h00, 1'b1);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b1);
      send_byte(8'h4D, 1'b0);
      send_byte(8'h61, 1'b0);
      send_byte(8'h6E, 1'b1);
      send_byte(8'hA5, 1'b0);
      send_byte(8'h5A, 1'b0);
      send_byte(8'h0F, 1'b0);
      send_byte(8'hF0, 1'b1);
      // zero limit acts as one: cut on first char, rest of message dropped
      set_limit(16'd0);
      send_byte(8'h12, 1'b0);
      send_byte(8'h34, 1'b0);
      send_byte(8'h56, 1'b1);
      // cut on the last byte itself
      set_limit(16'd1);
      send_byte(8'hC3, 1'b1);
      set_limit(16'd2);
      send_byte(8'h7E, 1'b1);
      // limit hit exactly on the natural final char: no truncation; then cuts at limit 3
      set_limit(16'd4);
      send_byte(8'h81, 1'b1);
      set_limit(16'd3);
      send_byte(8'h3C, 1'b0);
      send_byte(8'hE7, 1'b1);
      send_byte(8'h99, 1'b1);

      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               set_limit(16'hFFFF);
               send_idle_pct = 0;
               stall_pct     = 0;
               hold_req      = hold_req + 1;
            end
            1: begin
               set_limit(CountWidth'($urandom_range(1, 10)));
               send_idle_pct = 77;
               stall_pct     = 0;
            end
            2: begin
               set_limit(CountWidth'($urandom_range(4, 24)));
               send_idle_pct = 0;
               stall_pct     = 77;
            end
            default: begin
               set_limit(CountWidth'($urandom_range(2, 12)));
               send_idle_pct = 34;
               stall_pct     = 34;
            end
         endcase
         phase_bytes = 0;
         while (phase_bytes < 20) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(10, 20) : $urandom_range(1, 6);
            send_message(len);
            phase_bytes = phase_bytes + len;
         end
      end

      wait_drained();
      $display("Encoded %0d bytes in %0d messages; %0d characters checked, %0d cut by limit.",
               bytes_sent, messages_sent, chars_checked, cut_count);
      $display("Limits 0 to 65535, with and without sender gaps and receiver stalls.");
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
